### src/crl_pkg.sv
// Shared constants, codes, types and helpers for the controller sample ring block.
package crl_pkg;

	localparam int RING_DEPTH = 64;
	localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);
	localparam int SUM_W      = CNT_W + 1;
	localparam int PADDR_W    = 5;

	localparam logic [31:0] CENTER_WORD = 32'h8080_8080;
	localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		MODE_SAMPLE     = 3'd0,
		MODE_READ_BUF   = 3'd1,
		MODE_PEEK_BUF   = 3'd2,
		MODE_READ_LATCH = 3'd3,
		MODE_PEEK_LATCH = 3'd4,
		MODE_TICK       = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		STAT_ENTRY    = 2'd0,
		STAT_EMPTY    = 2'd1,
		STAT_BAD_SIZE = 2'd2,
		STAT_LATCH    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		REG_ANALOG_ENABLED = 3'd0,
		REG_USER_MASK      = 3'd1,
		REG_RF_ON          = 3'd2,
		REG_RF_PERIOD      = 3'd3,
		REG_RF_KEEP_MASK   = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STREAM,
		ST_STATUS,
		ST_LATCH
	} state_t;

	typedef struct packed {
		logic        analog_enabled;
		logic [31:0] user_visible_mask;
		logic        rapid_fire_on;
		logic [7:0]  rapid_fire_period;
		logic [31:0] rapid_fire_keep_mask;
		logic        rf_on_written;
	} cfg_t;

	typedef struct packed {
		logic [31:0] frame;
		logic [31:0] button;
		logic [31:0] analog;
	} entry_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] frame_stamp;
		logic [31:0] button_word;
		logic [31:0] analog_word;
		logic [31:0] made_mask;
		logic [31:0] broken_mask;
		logic [31:0] pressed_mask;
		logic [31:0] released_mask;
		logic [15:0] sample_count;
		logic        last_of_run;
	} result_t;

	function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] x);
		logic [IDX_W-1:0] r;
		if (x == IDX_W'(RING_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = x + 1'b1;
		end
		return r;
	endfunction

endpackage

### src/crl_regs.sv
// Configuration register file behind the APB-style port.
module crl_regs import crl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic        analog_enabled_q;
	logic [31:0] user_mask_q;
	logic        rf_on_q;
	logic [7:0]  rf_period_q;
	logic [31:0] rf_keep_q;
	logic        wr_en;
	reg_idx_t    idx;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			analog_enabled_q <= 1'b0;
			user_mask_q      <= ALL_ONES;
			rf_on_q          <= 1'b0;
			rf_period_q      <= 8'd5;
			rf_keep_q        <= 32'd240;
		end else if (wr_en) begin
			case (idx)
				REG_ANALOG_ENABLED: analog_enabled_q <= pwdata[0];
				REG_USER_MASK:      user_mask_q      <= pwdata;
				REG_RF_ON:          rf_on_q          <= pwdata[0];
				REG_RF_PERIOD:      rf_period_q      <= pwdata[7:0];
				REG_RF_KEEP_MASK:   rf_keep_q        <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ANALOG_ENABLED: prdata = {31'b0, analog_enabled_q};
			REG_USER_MASK:      prdata = user_mask_q;
			REG_RF_ON:          prdata = {31'b0, rf_on_q};
			REG_RF_PERIOD:      prdata = {24'b0, rf_period_q};
			REG_RF_KEEP_MASK:   prdata = rf_keep_q;
			default:            prdata = '0;
		endcase
	end

	always_comb begin
		cfg.analog_enabled       = analog_enabled_q;
		cfg.user_visible_mask    = user_mask_q;
		cfg.rapid_fire_on        = rf_on_q;
		cfg.rapid_fire_period    = rf_period_q;
		cfg.rapid_fire_keep_mask = rf_keep_q;
		// the toggle restarts whenever rapid fire is written
		cfg.rf_on_written        = wr_en && (idx == REG_RF_ON);
	end

endmodule

### src/crl_ring.sv
// Sample ring memory: one write port, one registered read port, per-entry valid bits.
module crl_ring import crl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data
);

	entry_t mem_q [RING_DEPTH];
	logic   valid_q [RING_DEPTH];
	entry_t rd_raw_q;
	logic   rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RING_DEPTH; i++) begin
				valid_q[i] <= 1'b0;
			end
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	// entries not written since reset read as zero frame and buttons and a centred analog word
	always_comb begin
		if (rd_valid_q) begin
			rd_data = rd_raw_q;
		end else begin
			rd_data.frame  = '0;
			rd_data.button = '0;
			rd_data.analog = CENTER_WORD;
		end
	end

endmodule

### src/controller_sample_ring_with_latch_core.sv
// Top level: request decode, ring control, input latches, rapid fire and result register.
// Sample, tick and ignored requests are handled as they are accepted. A latch request
// enters the latch state and its report is loaded into the result register as soon as
// that register is free. For a buffer read or peek returning N entries, the ring memory
// has one registered read port, so entries stream out one per cycle after the request
// cycle while the output is not stalled. Status-only results (empty or oversize) pass
// through the status state. The ring holds RING_DEPTH entries with a valid bit each,
// so no clearing pass follows reset. A new request is taken while the last result of
// the previous one still waits in the result register.
module controller_sample_ring_with_latch_core import crl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         mode,
	input  logic [31:0]        button_bits,
	input  logic [7:0]         left_x,
	input  logic [7:0]         left_y,
	input  logic [7:0]         right_x,
	input  logic [7:0]         right_y,
	input  logic [31:0]        time_stamp,
	input  logic [11:0]        entry_count,
	input  logic               invert,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [31:0]        frame_stamp,
	output logic [31:0]        button_word,
	output logic [31:0]        analog_word,
	output logic [31:0]        made_mask,
	output logic [31:0]        broken_mask,
	output logic [31:0]        pressed_mask,
	output logic [31:0]        released_mask,
	output logic [15:0]        sample_count,
	output logic               last_of_run
);

	localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(RING_DEPTH);

	cfg_t   cfg;
	state_t state_q, state_nxt;

	logic [IDX_W-1:0] wr_idx_q, rd_idx_q, rd_addr_q;
	logic [CNT_W-1:0] remain_q, avail_q;
	logic             invert_q, clear_q;
	status_t          status_q;
	logic [31:0]      prev_q, make_q, break_q, press_q, release_q;
	logic [15:0]      samples_q;
	logic [7:0]       tick_cnt_q;
	logic             toggle_q;
	result_t          out_q;
	logic             out_valid_q;

	mode_t            req_mode;
	logic             accept, out_free, out_load;
	logic             n_big;
	logic [CNT_W-1:0] n_cnt, used, avail;
	logic [SUM_W-1:0] w_ext, r_ext, a_ext, used_sum, start_sum;
	logic [IDX_W-1:0] start_idx, wr_next, rd_addr;
	logic             rd_en, wr_en;
	entry_t           wr_data, rd_data;
	logic [31:0]      smp_buttons, changed;
	logic [7:0]       tick_next;
	result_t          res;

	crl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	crl_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_idx_q),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign req_mode = mode_t'(mode);
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// request decode: window of entries for a read or peek
	always_comb begin
		n_big    = entry_count > 12'(RING_DEPTH);
		n_cnt    = CNT_W'(entry_count);
		w_ext    = SUM_W'(wr_idx_q);
		r_ext    = SUM_W'(rd_idx_q);
		used_sum = (w_ext >= r_ext) ? (w_ext - r_ext) : (w_ext + DEPTH_S - r_ext);
		used     = CNT_W'(used_sum);
		if (req_mode == MODE_PEEK_BUF || n_cnt < used) begin
			avail = n_cnt;
		end else begin
			avail = used;
		end
		a_ext     = SUM_W'(avail);
		start_sum = (w_ext >= a_ext) ? (w_ext - a_ext) : (w_ext + DEPTH_S - a_ext);
		start_idx = IDX_W'(start_sum);
	end

	// sample path
	always_comb begin
		smp_buttons = button_bits;
		if (cfg.rapid_fire_on && toggle_q) begin
			smp_buttons = button_bits & cfg.rapid_fire_keep_mask;
		end
		changed        = smp_buttons ^ prev_q;
		wr_en          = accept && (req_mode == MODE_SAMPLE);
		wr_data.frame  = time_stamp;
		wr_data.button = smp_buttons;
		wr_data.analog = cfg.analog_enabled ? {right_y, right_x, left_y, left_x}
			: CENTER_WORD;
		wr_next        = ring_inc(wr_idx_q);
		tick_next      = tick_cnt_q + 8'd1;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req_mode)
						MODE_READ_BUF, MODE_PEEK_BUF: begin
							if (n_big || avail == '0) begin
								state_nxt = ST_STATUS;
							end else begin
								state_nxt = ST_STREAM;
							end
						end
						MODE_READ_LATCH, MODE_PEEK_LATCH: state_nxt = ST_LATCH;
						default: state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_STREAM: begin
				if (out_free && remain_q == CNT_W'(1)) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_STATUS, ST_LATCH: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs of the sequencer: ring reads and result loads
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = rd_addr_q;
		out_load = 1'b0;
		res      = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (req_mode == MODE_READ_BUF || req_mode == MODE_PEEK_BUF)
					&& !n_big && avail != '0) begin
					rd_en   = 1'b1;
					rd_addr = start_idx;
				end
			end
			ST_STREAM: begin
				out_load         = out_free;
				res.status       = STAT_ENTRY;
				res.frame_stamp  = rd_data.frame;
				res.button_word  = (rd_data.button & cfg.user_visible_mask) ^ {32{invert_q}};
				res.analog_word  = rd_data.analog;
				res.sample_count = 16'(avail_q);
				res.last_of_run  = (remain_q == CNT_W'(1));
				// fetch the next entry while this one goes out
				if (out_free && remain_q != CNT_W'(1)) begin
					rd_en = 1'b1;
				end
			end
			ST_STATUS: begin
				out_load        = out_free;
				res.status      = status_q;
				res.last_of_run = 1'b1;
			end
			ST_LATCH: begin
				out_load          = out_free;
				res.status        = STAT_LATCH;
				res.made_mask     = make_q & cfg.user_visible_mask;
				res.broken_mask   = break_q & cfg.user_visible_mask;
				res.pressed_mask  = press_q & cfg.user_visible_mask;
				res.released_mask = release_q
					| ((samples_q != 16'd0) ? ~cfg.user_visible_mask : 32'd0);
				res.sample_count  = samples_q;
				res.last_of_run   = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wr_idx_q    <= IDX_W'(1);
			rd_idx_q    <= '0;
			prev_q      <= '0;
			make_q      <= '0;
			break_q     <= '0;
			press_q     <= '0;
			release_q   <= ALL_ONES;
			samples_q   <= '0;
			tick_cnt_q  <= '0;
			toggle_q    <= 1'b1;
			out_valid_q <= 1'b0;
			rd_addr_q   <= '0;
			remain_q    <= '0;
			avail_q     <= '0;
			invert_q    <= 1'b0;
			clear_q     <= 1'b0;
			status_q    <= STAT_EMPTY;
		end else begin
			state_q <= state_nxt;

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (cfg.rf_on_written) begin
				toggle_q <= 1'b1;
			end

			if (accept) begin
				case (req_mode)
					MODE_SAMPLE: begin
						make_q    <= make_q | (smp_buttons & changed);
						break_q   <= break_q | (prev_q & changed);
						press_q   <= press_q | smp_buttons;
						release_q <= release_q | ~smp_buttons;
						if (samples_q != 16'hFFFF) begin
							samples_q <= samples_q + 16'd1;
						end
						prev_q   <= smp_buttons;
						wr_idx_q <= wr_next;
						// full ring: drop the oldest unread entry
						if (rd_idx_q == wr_next) begin
							rd_idx_q <= ring_inc(rd_idx_q);
						end
					end
					MODE_READ_BUF, MODE_PEEK_BUF: begin
						status_q  <= n_big ? STAT_BAD_SIZE : STAT_EMPTY;
						rd_addr_q <= ring_inc(start_idx);
						remain_q  <= avail;
						avail_q   <= avail;
						invert_q  <= invert;
						if (req_mode == MODE_READ_BUF && !n_big) begin
							rd_idx_q <= wr_idx_q;
						end
					end
					MODE_READ_LATCH, MODE_PEEK_LATCH: begin
						clear_q <= (req_mode == MODE_READ_LATCH);
					end
					MODE_TICK: begin
						if (tick_next >= cfg.rapid_fire_period) begin
							tick_cnt_q <= '0;
							toggle_q   <= ~toggle_q;
						end else begin
							tick_cnt_q <= tick_next;
						end
					end
					default: ;
				endcase
			end

			if (state_q == ST_STREAM && out_free) begin
				remain_q <= remain_q - CNT_W'(1);
				if (remain_q != CNT_W'(1)) begin
					rd_addr_q <= ring_inc(rd_addr_q);
				end
			end

			if (state_q == ST_LATCH && out_free && clear_q) begin
				make_q    <= '0;
				break_q   <= '0;
				press_q   <= '0;
				release_q <= '0;
				samples_q <= '0;
			end
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign frame_stamp   = out_q.frame_stamp;
	assign button_word   = out_q.button_word;
	assign analog_word   = out_q.analog_word;
	assign made_mask     = out_q.made_mask;
	assign broken_mask   = out_q.broken_mask;
	assign pressed_mask  = out_q.pressed_mask;
	assign released_mask = out_q.released_mask;
	assign sample_count  = out_q.sample_count;
	assign last_of_run   = out_q.last_of_run;

endmodule
